@@ sv/chord_tone_synthesizer_macros.svh @@
// Assertion macros shared by the chord tone synthesizer RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef CHORD_TONE_SYNTHESIZER_MACROS_SVH
`define CHORD_TONE_SYNTHESIZER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CTSYN_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define CTSYN_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/ctsyn_pkg.sv @@
// Package for the chord tone synthesizer: widths, register indexes and reset values.
// It also holds the quarter-wave sine function used to build the sine table.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctsyn_pkg;

	localparam int NOTES_DEF          = 3;
	localparam int SINE_ADDR_BITS_DEF = 10;
	localparam int PHASE_BITS_DEF     = 32;

	localparam int STEP_REGS  = 3;
	localparam int STEP_W     = 32;
	localparam int COUNT_W    = 2;
	localparam int AMP_W      = 15;
	localparam int SINE_W     = 15;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FULL_SCALE = 32767;

	localparam logic [CFG_IDX_W-1:0] REG_NOTE0_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE1_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE2_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd4;

	localparam logic [STEP_W-1:0]  NOTE0_STEP_RST = 32'd25480538;
	localparam logic [STEP_W-1:0]  NOTE1_STEP_RST = 32'd32103162;
	localparam logic [STEP_W-1:0]  NOTE2_STEP_RST = 32'd38177487;
	localparam logic [COUNT_W-1:0] NOTE_COUNT_RST = 2'd3;
	localparam logic [AMP_W-1:0]   AMPLITUDE_RST  = 15'd10000;

	localparam longint unsigned QONE        = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Quarter-wave sine in unsigned Q0.15 for k in 0..2^(sab-2), from an odd Taylor series in Q30.
	function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
			input int unsigned sab);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		x  = (64'(k) * HALF_PI_Q30) >> (sab - 2);
		x2 = (x * x) >> 30;
		t  = QONE;
		t  = QONE - (((x2 * t) >> 30) / 64'd110);
		t  = QONE - (((x2 * t) >> 30) / 64'd72);
		t  = QONE - (((x2 * t) >> 30) / 64'd42);
		t  = QONE - (((x2 * t) >> 30) / 64'd20);
		t  = QONE - (((x2 * t) >> 30) / 64'd6);
		s  = (x * t) >> 30;
		v  = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
		if (v > 64'(FULL_SCALE)) begin
			v = 64'(FULL_SCALE);
		end
		return v[SINE_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/ctsyn_cfg_if.sv @@
// Configuration write channel of the chord tone synthesizer.
// Depends on ctsyn_pkg for the index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface ctsyn_cfg_if import ctsyn_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/ctsyn_tick_if.sv @@
// Sample tick channel of the chord tone synthesizer; one beat asks for one sample.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ctsyn_tick_if ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ sv/ctsyn_audio_if.sv @@
// Sample output channel of the chord tone synthesizer.
// Depends on ctsyn_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface ctsyn_audio_if import ctsyn_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ sv/chord_tone_synthesizer.sv @@
// Chord tone synthesizer: one signed 16-bit sample per tick beat, amplitude times the mean of
// up to NOTES sines taken from per-note phase accumulators. Depends on ctsyn_pkg, the three
// channel interfaces and chord_tone_synthesizer_macros.svh.
//
// A tick beat is taken only while the block is idle, and the block goes back to idle only when
// the sample is loaded into the output register, so a new beat waits for the last sample.
// One adder serves the running sum and the division under a small sequencer: per note a sine
// table read and then a step of the running sum, the amplitude multiply, then one quotient bit
// per cycle for the fifteen-bit division by note_count times full scale. The sample waits in
// an output register, and configuration writes are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "chord_tone_synthesizer_macros.svh"

module chord_tone_synthesizer import ctsyn_pkg::*; #(
	parameter int NOTES          = NOTES_DEF,
	parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
	parameter int PHASE_BITS     = PHASE_BITS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	ctsyn_cfg_if.sink     cfg,
	ctsyn_tick_if.sink    tick,
	ctsyn_audio_if.source audio
);

	localparam int RW      = SINE_ADDR_BITS - 2;
	localparam int KW      = SINE_ADDR_BITS - 1;
	localparam int QDEPTH  = 2 ** RW + 1;
	localparam int NIDX_W  = (NOTES > 1) ? $clog2(NOTES) : 1;
	localparam int CNT_W   = $clog2(NOTES + 1);
	localparam int SUM_W   = 16 + $clog2(NOTES);
	localparam int PROD_W  = SUM_W + 16;
	localparam int QUO_W   = SINE_W;
	localparam int DEN_W   = SINE_W + CNT_W;
	localparam int DIVC_W  = $clog2(QUO_W);
	localparam int ALU_W   = ((SUM_W > DEN_W + 1) ? SUM_W : DEN_W + 1) + 1;
	localparam int WIDE_W  = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DINIT = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]            state_q;
	logic [NIDX_W-1:0]     idx_q;
	logic [DIVC_W-1:0]     divc_q;
	logic [PHASE_BITS-1:0] phase_q [NOTES];
	logic                  out_valid_q;

	logic [STEP_W-1:0]  step_q [STEP_REGS];
	logic [COUNT_W-1:0] ncount_q;
	logic [AMP_W-1:0]   amp_q;

	logic                       restart_q;
	logic [CNT_W-1:0]           count_q;
	logic [SINE_W-1:0]          rom_s1;
	logic                       neg_s1;
	logic                       act_s1;
	logic signed [SUM_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       sneg_q;
	logic [DEN_W-1:0]           rem_q;
	logic [DEN_W-1:0]           den_q;
	logic [QUO_W-1:0]           low_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [SINE_W-1:0]         qsine_tab [QDEPTH];
	logic [CNT_W-1:0]          eff_count;
	logic [STEP_W-1:0]         step_sel;
	logic [PHASE_BITS-1:0]     ph_base;
	logic [WIDE_W-1:0]         ph_sum;
	logic [PHASE_BITS-1:0]     ph_next;
	logic [SINE_ADDR_BITS-1:0] addr;
	logic [1:0]                quad;
	logic [RW-1:0]             rpos;
	logic [KW-1:0]             qk;
	logic                      act;
	logic [PROD_W-1:0]         mag;
	logic signed [ALU_W-1:0]   alu_a;
	logic signed [ALU_W-1:0]   alu_b;
	logic signed [ALU_W-1:0]   alu_y;
	logic                      qbit;
	logic                      tick_take;
	logic                      out_load;

	for (genvar g = 0; g < QDEPTH; g++) begin : g_qsine
		assign qsine_tab[g] = quarter_sine(g, SINE_ADDR_BITS);
	end

	assign cfg.ready    = 1'b1;
	assign tick.ready   = (state_q == ST_IDLE);
	assign audio.valid  = out_valid_q;
	assign audio.sample = sample_q;

	assign tick_take = tick.valid && (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || audio.ready);

	always_comb begin
		if (ncount_q == '0) begin
			eff_count = CNT_W'(1);
		end else if (int'(ncount_q) > NOTES) begin
			eff_count = CNT_W'(NOTES);
		end else begin
			eff_count = CNT_W'(ncount_q);
		end
	end

	always_comb begin
		step_sel = '0;
		for (int j = 0; j < STEP_REGS; j++) begin
			if (int'(idx_q) == j) begin
				step_sel = step_q[j];
			end
		end
	end

	assign ph_base = restart_q ? '0 : phase_q[idx_q];
	assign ph_sum  = WIDE_W'(ph_base) + WIDE_W'(step_sel);
	assign ph_next = ph_sum[PHASE_BITS-1:0];
	assign addr    = ph_base[PHASE_BITS-1 -: SINE_ADDR_BITS];
	assign quad    = addr[SINE_ADDR_BITS-1 -: 2];
	assign rpos    = addr[RW-1:0];
	assign qk      = quad[0] ? (KW'(QDEPTH - 1) - KW'(rpos)) : KW'(rpos);
	assign act     = int'(idx_q) < int'(count_q);
	assign mag     = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

	// The adder sums the sines, then makes the trial subtraction of the division.
	always_comb begin
		if (state_q == ST_DIV) begin
			alu_a = ALU_W'({rem_q, low_q[QUO_W-1]});
			alu_b = -ALU_W'(den_q);
		end else begin
			alu_a = ALU_W'(acc_q);
			if (!act_s1) begin
				alu_b = '0;
			end else if (neg_s1) begin
				alu_b = -ALU_W'(rom_s1);
			end else begin
				alu_b = ALU_W'(rom_s1);
			end
		end
		alu_y = alu_a + alu_b;
	end

	assign qbit = !alu_y[ALU_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			divc_q      <= '0;
			out_valid_q <= 1'b0;
			for (int n = 0; n < NOTES; n++) begin
				phase_q[n] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (audio.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_take) begin
						idx_q   <= '0;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					phase_q[idx_q] <= ph_next;
					state_q        <= ST_ACC;
				end
				ST_ACC: begin
					if (idx_q == NIDX_W'(NOTES - 1)) begin
						state_q <= ST_MUL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_LOOK;
					end
				end
				ST_MUL: begin
					state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					divc_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (divc_q == DIVC_W'(QUO_W - 1)) begin
						state_q <= ST_FIN;
					end else begin
						divc_q <= divc_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q[0] <= NOTE0_STEP_RST;
			step_q[1] <= NOTE1_STEP_RST;
			step_q[2] <= NOTE2_STEP_RST;
			ncount_q  <= NOTE_COUNT_RST;
			amp_q     <= AMPLITUDE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NOTE0_STEP: step_q[0] <= cfg.data[STEP_W-1:0];
				REG_NOTE1_STEP: step_q[1] <= cfg.data[STEP_W-1:0];
				REG_NOTE2_STEP: step_q[2] <= cfg.data[STEP_W-1:0];
				REG_NOTE_COUNT: ncount_q  <= cfg.data[COUNT_W-1:0];
				REG_AMPLITUDE:  amp_q     <= cfg.data[AMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			restart_q <= tick.restart;
			count_q   <= eff_count;
			acc_q     <= '0;
		end
		if (state_q == ST_LOOK) begin
			rom_s1 <= qsine_tab[qk];
			neg_s1 <= quad[1];
			act_s1 <= act;
		end
		if (state_q == ST_ACC) begin
			acc_q <= SUM_W'(alu_y);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'($signed({1'b0, amp_q}) * acc_q);
		end
		if (state_q == ST_DINIT) begin
			sneg_q <= prod_q[PROD_W-1];
			rem_q  <= DEN_W'(mag >> QUO_W);
			low_q  <= mag[QUO_W-1:0];
			den_q  <= DEN_W'(DEN_W'(count_q) * DEN_W'(FULL_SCALE));
		end
		if (state_q == ST_DIV) begin
			rem_q <= qbit ? DEN_W'(alu_y) : DEN_W'({rem_q, low_q[QUO_W-1]});
			low_q <= {low_q[QUO_W-2:0], qbit};
		end
		if (out_load) begin
			sample_q <= sneg_q ? -SAMPLE_W'(low_q) : SAMPLE_W'(low_q);
		end
	end

	`CTSYN_ASSERT(a_rem_below_den, (state_q == ST_DIV) |-> (rem_q < den_q), "Division remainder reached the divisor.")
	`CTSYN_ASSERT(a_load_from_fin, $rose(out_valid_q) |-> ($past(state_q) == ST_FIN), "Sample register loaded outside the final step.")
	`CTSYN_ASSERT(a_count_range, (state_q != ST_IDLE) |-> ((count_q != '0) && (int'(count_q) <= NOTES)), "Active note count out of range.")
	`CTSYN_ASSERT_NEVER(a_idx_range, ((state_q == ST_LOOK) || (state_q == ST_ACC)) && (int'(idx_q) >= NOTES), "Note index beyond the last note.")

endmodule

`default_nettype wire
